// ----- hdl/hsme_pkg.sv -----
// ----------------------------------------------------------------------------
// hsme_pkg
// Shared types, codes and helpers of the hierarchical state machine engine.
// ----------------------------------------------------------------------------
`default_nettype none

package hsme_pkg;

	// sizes
	localparam int STATE_COUNT = 64;
	localparam int STATE_W     = 6;
	localparam int LINK_W      = 7;
	localparam int NEST        = 8;
	localparam int NEST_W      = 4;
	localparam int BUF_DEPTH   = 2 * NEST;
	localparam int BUF_W       = 5;

	typedef logic [STATE_W-1:0] state_t;
	typedef logic [LINK_W-1:0]  link_t;
	typedef logic [1:0]         kind_t;

	// request codes
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_EVENT = 2'd2;

	// notification codes
	localparam kind_t ACT_EXIT    = 2'd0;
	localparam kind_t ACT_ENTER   = 2'd1;
	localparam kind_t ACT_DEFAULT = 2'd2;
	localparam kind_t ACT_DONE    = 2'd3;

	// configuration register indexes
	localparam logic CFG_INITIAL = 1'b0;
	localparam logic CFG_COUNT   = 1'b1;

	// one table entry
	typedef struct packed {
		link_t par;
		link_t dch;
		logic  flag;
	} ent_t;

	// table memory access from the sequencer
	typedef struct packed {
		logic   rd_en;
		state_t rd_addr;
		logic   wr_en;
		state_t wr_addr;
		ent_t   wr_data;
		logic   hwr_en;
		state_t hwr_addr;
		state_t hwr_data;
		logic   hclr;
	} tbl_req_t;

	// one or two notifications into the result buffer
	typedef struct packed {
		logic   en;
		logic   pair;
		kind_t  kind;
		state_t st;
	} res_push_t;

	// end of the work on one request
	typedef struct packed {
		logic   en;
		state_t leaf;
		logic   matched;
	} res_fin_t;

	function automatic link_t count_in_use(input link_t n);
		if (n == '0) return link_t'(1);
		if (n > link_t'(STATE_COUNT)) return link_t'(STATE_COUNT);
		return n;
	endfunction

	function automatic logic state_ok(input state_t v, input link_t cnt);
		return {1'b0, v} < cnt;
	endfunction

	function automatic logic link_ok(input link_t raw, input link_t cnt);
		return !raw[LINK_W-1] && ({1'b0, raw[STATE_W-1:0]} < cnt);
	endfunction

endpackage

`default_nettype wire

// ----- hdl/hsme_tables.sv -----
// ----------------------------------------------------------------------------
// hsme_tables
// Entry memory (parent, default child, history flag) and history memory,
// both with registered read data; history valid bits clear at once.
// ----------------------------------------------------------------------------
`default_nettype none

module hsme_tables (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire hsme_pkg::tbl_req_t  req,
	output hsme_pkg::ent_t           ent_rd,
	output hsme_pkg::state_t         hist_rd,
	output logic                     hist_vld
);

	hsme_pkg::ent_t   ent_mem [hsme_pkg::STATE_COUNT];
	hsme_pkg::state_t hist_mem [hsme_pkg::STATE_COUNT];
	logic [hsme_pkg::STATE_COUNT-1:0] hvld_q;
	hsme_pkg::ent_t   ent_q;
	hsme_pkg::state_t hist_q;
	logic             hv_q;

	// entry memory
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			ent_mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			ent_q <= ent_mem[req.rd_addr];
		end
	end

	// history memory
	always_ff @(posedge clk) begin
		if (req.hwr_en) begin
			hist_mem[req.hwr_addr] <= req.hwr_data;
		end
		if (req.rd_en) begin
			hist_q <= hist_mem[req.rd_addr];
			hv_q   <= hvld_q[req.rd_addr];
		end
	end

	// history valid bits: none recorded after reset or start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hvld_q <= '0;
		end else if (req.hclr) begin
			hvld_q <= '0;
		end else if (req.hwr_en) begin
			hvld_q[req.hwr_addr] <= 1'b1;
		end
	end

	assign ent_rd   = ent_q;
	assign hist_rd  = hist_q;
	assign hist_vld = hv_q;

endmodule

`default_nettype wire

// ----- hdl/hsme_results.sv -----
// ----------------------------------------------------------------------------
// hsme_results
// Collects the notifications of one request, then sends them and the
// completion through the output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module hsme_results (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire hsme_pkg::res_push_t push,
	input  wire hsme_pkg::res_fin_t  fin,
	output logic                     busy,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output hsme_pkg::kind_t          action_kind,
	output hsme_pkg::state_t         action_state,
	output hsme_pkg::state_t         active_leaf,
	output logic                     event_matched,
	output logic                     last_of_run
);

	hsme_pkg::kind_t  bk_q [hsme_pkg::BUF_DEPTH];
	hsme_pkg::state_t bs_q [hsme_pkg::BUF_DEPTH];
	logic [hsme_pkg::BUF_W-1:0] wc_q, rc_q, wc1;
	logic             busy_q, ov_q, load, more;
	hsme_pkg::state_t leaf_q;
	logic             match_q;
	hsme_pkg::kind_t  ok_q;
	hsme_pkg::state_t os_q, ol_q;
	logic             om_q, olast_q;

	assign wc1  = wc_q + hsme_pkg::BUF_W'(1);
	assign load = busy_q && (!ov_q || out_ready);
	assign more = rc_q < wc_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q   <= '0;
			rc_q   <= '0;
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			if (push.en) begin
				wc_q <= push.pair ? wc_q + hsme_pkg::BUF_W'(2) : wc1;
			end
			if (fin.en) begin
				busy_q <= 1'b1;
				rc_q   <= '0;
			end
			if (load) begin
				ov_q <= 1'b1;
				if (more) begin
					rc_q <= rc_q + hsme_pkg::BUF_W'(1);
				end else begin
					busy_q <= 1'b0;
					wc_q   <= '0;
				end
			end else if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// buffer and output payload
	always_ff @(posedge clk) begin
		if (push.en) begin
			bk_q[wc_q[hsme_pkg::BUF_W-2:0]] <= push.kind;
			bs_q[wc_q[hsme_pkg::BUF_W-2:0]] <= push.st;
			if (push.pair) begin
				bk_q[wc1[hsme_pkg::BUF_W-2:0]] <= hsme_pkg::ACT_ENTER;
				bs_q[wc1[hsme_pkg::BUF_W-2:0]] <= push.st;
			end
		end
		if (fin.en) begin
			leaf_q  <= fin.leaf;
			match_q <= fin.matched;
		end
		if (load) begin
			ol_q <= leaf_q;
			om_q <= match_q;
			if (more) begin
				ok_q    <= bk_q[rc_q[hsme_pkg::BUF_W-2:0]];
				os_q    <= bs_q[rc_q[hsme_pkg::BUF_W-2:0]];
				olast_q <= 1'b0;
			end else begin
				ok_q    <= hsme_pkg::ACT_DONE;
				os_q    <= leaf_q;
				olast_q <= 1'b1;
			end
		end
	end

	assign busy          = busy_q;
	assign out_valid     = ov_q;
	assign action_kind   = ok_q;
	assign action_state  = os_q;
	assign active_leaf   = ol_q;
	assign event_matched = om_q;
	assign last_of_run   = olast_q;

`ifndef SYNTHESIS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.en |-> (wc_q < hsme_pkg::BUF_W'(hsme_pkg::BUF_DEPTH - 1)) ||
			(!push.pair && wc_q < hsme_pkg::BUF_W'(hsme_pkg::BUF_DEPTH)))
		else $error("result buffer overflow");
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fin.en |-> !busy_q)
		else $error("request finished while results drain");
	a_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		push.en |-> !busy_q)
		else $error("notification pushed while results drain");
`endif

endmodule

`default_nettype wire

// ----- hdl/hsme_ctrl.sv -----
// ----------------------------------------------------------------------------
// hsme_ctrl
// Sequencer: table writes, start descent, and the event walk (ancestries,
// exits with history recording, entries and descent to a leaf).
// ----------------------------------------------------------------------------
`default_nettype none

module hsme_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [1:0]          req_type,
	input  wire logic [5:0]          entry_index,
	input  wire logic [6:0]          parent_of_entry,
	input  wire logic [6:0]          default_child_of_entry,
	input  wire logic                entry_keeps_history,
	input  wire logic                event_handled,
	input  wire logic [2:0]          handler_level,
	input  wire logic [5:0]          dest_state,
	input  wire logic                cfg_valid,
	input  wire logic                cfg_index,
	input  wire logic [6:0]          cfg_data,
	input  wire logic                res_busy,
	input  wire hsme_pkg::ent_t      ent_rd,
	input  wire hsme_pkg::state_t    hist_rd,
	input  wire logic                hist_vld,
	output hsme_pkg::tbl_req_t       req,
	output hsme_pkg::res_push_t      push,
	output hsme_pkg::res_fin_t       fin
);

	typedef enum logic [3:0] {
		S_IDLE, S_START, S_LC, S_LCEND, S_DC, S_EXIT,
		S_SEL, S_XC, S_CMP, S_ENTER, S_DESC
	} st_t;

	typedef logic [hsme_pkg::NEST_W-1:0]   cnt_t;
	typedef logic [hsme_pkg::NEST_W-2:0]   idx_t;

	st_t              state_q, state_d;
	logic             started_q, started_d;
	hsme_pkg::state_t leaf_q, leaf_d, init_q, init_d;
	hsme_pkg::link_t  nst_q, nst_d, cnt;

	hsme_pkg::state_t s_q, s_d, dest_q, dest_d, last_q, last_d;
	logic [2:0]       lvl_q, lvl_d;
	cnt_t             k_q, k_d, n_q, n_d, dn_q, dn_d, xn_q, xn_d, e_q, e_d, ent_q, ent_d;
	idx_t             j_q, j_d;
	hsme_pkg::state_t lc_q [hsme_pkg::NEST];
	hsme_pkg::state_t lc_d [hsme_pkg::NEST];
	hsme_pkg::state_t lcp_q [hsme_pkg::NEST];
	hsme_pkg::state_t lcp_d [hsme_pkg::NEST];
	logic [hsme_pkg::NEST-1:0] pf_q, pf_d;
	hsme_pkg::state_t dc_q [hsme_pkg::NEST];
	hsme_pkg::state_t dc_d [hsme_pkg::NEST];
	hsme_pkg::state_t xc_q [hsme_pkg::NEST];
	hsme_pkg::state_t xc_d [hsme_pkg::NEST];

	logic             indc, found;
	idx_t             pm, first;
	cnt_t             mx, pcmp, km1;
	hsme_pkg::state_t cur, nxt;
	logic             hv, nv;

	assign cnt      = hsme_pkg::count_in_use(nst_q);
	assign in_ready = (state_q == S_IDLE) && !res_busy;
	assign cur      = lc_q[e_q[hsme_pkg::NEST_W-2:0]];
	assign km1      = k_q - cnt_t'(1);

	// is the exit candidate an ancestor of the destination
	always_comb begin
		indc = 1'b0;
		for (int j = 0; j < hsme_pkg::NEST; j++) begin
			if (cnt_t'(j) < dn_q && dc_q[j] == cur) indc = 1'b1;
		end
	end

	// topmost place of the last exited state in the destination ancestry
	always_comb begin
		pm    = '0;
		found = 1'b0;
		for (int j = 0; j < hsme_pkg::NEST; j++) begin
			if (cnt_t'(j) < dn_q && dc_q[j] == last_q) begin
				pm    = idx_t'(j);
				found = 1'b1;
			end
		end
	end

	// common top part of the two ancestries
	always_comb begin
		logic [hsme_pkg::NEST_W-1:0] xi, di;
		mx    = ((dn_q < xn_q) ? dn_q : xn_q) - cnt_t'(1);
		first = mx[hsme_pkg::NEST_W-2:0];
		for (int i = hsme_pkg::NEST - 1; i >= 0; i--) begin
			xi = xn_q - cnt_t'(1) - cnt_t'(i);
			di = dn_q - cnt_t'(1) - cnt_t'(i);
			if (cnt_t'(i) <= mx &&
				xc_q[xi[hsme_pkg::NEST_W-2:0]] != dc_q[di[hsme_pkg::NEST_W-2:0]]) begin
				first = idx_t'(i);
			end
		end
		pcmp = dn_q - cnt_t'(1) - {1'b0, first};
	end

	// next child on descent: history first, then default child
	assign hv  = hist_vld && hsme_pkg::state_ok(hist_rd, cnt);
	assign nxt = hv ? hist_rd : ent_rd.dch[hsme_pkg::STATE_W-1:0];
	assign nv  = hv || hsme_pkg::link_ok(ent_rd.dch, cnt);

	// sequencer next state
	always_comb begin
		state_d   = state_q;
		started_d = started_q;
		leaf_d    = leaf_q;
		init_d    = init_q;
		nst_d     = nst_q;
		s_d = s_q; dest_d = dest_q; last_d = last_q; lvl_d = lvl_q;
		k_d = k_q; n_d = n_q; dn_d = dn_q; xn_d = xn_q; e_d = e_q;
		ent_d = ent_q; j_d = j_q;
		lc_d = lc_q; lcp_d = lcp_q; pf_d = pf_q; dc_d = dc_q; xc_d = xc_q;
		req  = '0;
		push = '0;
		fin  = '0;

		// configuration writes
		if (cfg_valid) begin
			case (cfg_index)
				hsme_pkg::CFG_INITIAL: init_d = cfg_data[hsme_pkg::STATE_W-1:0];
				hsme_pkg::CFG_COUNT:   nst_d  = cfg_data;
				default: ;
			endcase
		end

		case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					lvl_d  = handler_level;
					dest_d = dest_state;
					fin.leaf    = leaf_q;
					fin.matched = 1'b0;
					case (req_type)
						hsme_pkg::REQ_WRITE: begin
							req.wr_en        = hsme_pkg::state_ok(entry_index, cnt);
							req.wr_addr      = entry_index;
							req.wr_data.par  = parent_of_entry;
							req.wr_data.dch  = default_child_of_entry;
							req.wr_data.flag = entry_keeps_history;
							fin.en = 1'b1;
						end
						hsme_pkg::REQ_START: begin
							req.hclr = 1'b1;
							if (hsme_pkg::state_ok(init_q, cnt)) begin
								req.rd_en   = 1'b1;
								req.rd_addr = init_q;
								s_d     = init_q;
								k_d     = '0;
								state_d = S_START;
							end else begin
								fin.en = 1'b1;
							end
						end
						hsme_pkg::REQ_EVENT: begin
							if (event_handled && started_q &&
								hsme_pkg::state_ok(dest_state, cnt) &&
								hsme_pkg::state_ok(leaf_q, cnt)) begin
								req.rd_en   = 1'b1;
								req.rd_addr = leaf_q;
								s_d     = leaf_q;
								k_d     = '0;
								state_d = S_LC;
							end else begin
								fin.en = 1'b1;
							end
						end
						default: fin.en = 1'b1;
					endcase
				end
			end

			// default-entry and entry down the default chain
			S_START: begin
				push.en   = 1'b1;
				push.pair = 1'b1;
				push.kind = hsme_pkg::ACT_DEFAULT;
				push.st   = s_q;
				leaf_d    = s_q;
				if (hsme_pkg::link_ok(ent_rd.dch, cnt) &&
					k_q < cnt_t'(hsme_pkg::NEST - 1)) begin
					req.rd_en   = 1'b1;
					req.rd_addr = ent_rd.dch[hsme_pkg::STATE_W-1:0];
					s_d = ent_rd.dch[hsme_pkg::STATE_W-1:0];
					k_d = k_q + cnt_t'(1);
				end else begin
					started_d   = 1'b1;
					fin.en      = 1'b1;
					fin.leaf    = s_q;
					fin.matched = 1'b0;
					state_d     = S_IDLE;
				end
			end

			// leaf ancestry, with parent flags; one extra read past the top
			S_LC: begin
				if (k_q != '0) pf_d[km1[hsme_pkg::NEST_W-2:0]] = ent_rd.flag;
				if (k_q[hsme_pkg::NEST_W-1]) begin
					n_d     = cnt_t'(hsme_pkg::NEST);
					state_d = S_LCEND;
				end else begin
					lc_d[k_q[hsme_pkg::NEST_W-2:0]]  = s_q;
					lcp_d[k_q[hsme_pkg::NEST_W-2:0]] = ent_rd.par[hsme_pkg::STATE_W-1:0];
					if (hsme_pkg::link_ok(ent_rd.par, cnt)) begin
						req.rd_en   = 1'b1;
						req.rd_addr = ent_rd.par[hsme_pkg::STATE_W-1:0];
						s_d = ent_rd.par[hsme_pkg::STATE_W-1:0];
						k_d = k_q + cnt_t'(1);
					end else begin
						pf_d[k_q[hsme_pkg::NEST_W-2:0]] = 1'b0;
						n_d     = k_q + cnt_t'(1);
						state_d = S_LCEND;
					end
				end
			end

			// handler beyond the ancestry: no transition; else read the destination
			S_LCEND: begin
				if ({1'b0, lvl_q} >= n_q) begin
					fin.en      = 1'b1;
					fin.leaf    = leaf_q;
					fin.matched = 1'b0;
					state_d     = S_IDLE;
				end else begin
					req.rd_en   = 1'b1;
					req.rd_addr = dest_q;
					s_d     = dest_q;
					k_d     = '0;
					state_d = S_DC;
				end
			end

			// destination ancestry
			S_DC: begin
				dc_d[k_q[hsme_pkg::NEST_W-2:0]] = s_q;
				if (hsme_pkg::link_ok(ent_rd.par, cnt) &&
					k_q < cnt_t'(hsme_pkg::NEST - 1)) begin
					req.rd_en   = 1'b1;
					req.rd_addr = ent_rd.par[hsme_pkg::STATE_W-1:0];
					s_d = ent_rd.par[hsme_pkg::STATE_W-1:0];
					k_d = k_q + cnt_t'(1);
				end else begin
					dn_d    = k_q + cnt_t'(1);
					e_d     = '0;
					ent_d   = '0;
					state_d = S_EXIT;
				end
			end

			// exits from the leaf upward, recording shallow history
			S_EXIT: begin
				if (e_q <= {1'b0, lvl_q} || !indc || cur == dest_q) begin
					push.en   = 1'b1;
					push.kind = hsme_pkg::ACT_EXIT;
					push.st   = cur;
					last_d    = cur;
					req.hwr_en   = pf_q[e_q[hsme_pkg::NEST_W-2:0]];
					req.hwr_addr = lcp_q[e_q[hsme_pkg::NEST_W-2:0]];
					req.hwr_data = cur;
				end
				if ((e_q <= {1'b0, lvl_q} || !indc) && e_q + cnt_t'(1) < n_q) begin
					e_d = e_q + cnt_t'(1);
				end else begin
					state_d = S_SEL;
				end
			end

			// first state to enter
			S_SEL: begin
				if (found) begin
					j_d     = pm;
					state_d = S_ENTER;
				end else begin
					req.rd_en   = 1'b1;
					req.rd_addr = last_q;
					s_d     = last_q;
					k_d     = '0;
					state_d = S_XC;
				end
			end

			// ancestry of the last exited state
			S_XC: begin
				xc_d[k_q[hsme_pkg::NEST_W-2:0]] = s_q;
				if (hsme_pkg::link_ok(ent_rd.par, cnt) &&
					k_q < cnt_t'(hsme_pkg::NEST - 1)) begin
					req.rd_en   = 1'b1;
					req.rd_addr = ent_rd.par[hsme_pkg::STATE_W-1:0];
					s_d = ent_rd.par[hsme_pkg::STATE_W-1:0];
					k_d = k_q + cnt_t'(1);
				end else begin
					xn_d    = k_q + cnt_t'(1);
					state_d = S_CMP;
				end
			end

			S_CMP: begin
				j_d     = pcmp[hsme_pkg::NEST_W-2:0];
				state_d = S_ENTER;
			end

			// entries down to the destination
			S_ENTER: begin
				push.en   = 1'b1;
				push.kind = hsme_pkg::ACT_ENTER;
				push.st   = dc_q[j_q];
				ent_d     = ent_q + cnt_t'(1);
				if (j_q == '0) begin
					req.rd_en   = 1'b1;
					req.rd_addr = dest_q;
					s_d     = dest_q;
					state_d = S_DESC;
				end else begin
					j_d = j_q - idx_t'(1);
				end
			end

			// descent through history or default children
			S_DESC: begin
				if (ent_q < cnt_t'(hsme_pkg::NEST) && nv) begin
					push.en     = 1'b1;
					push.kind   = hsme_pkg::ACT_ENTER;
					push.st     = nxt;
					ent_d       = ent_q + cnt_t'(1);
					s_d         = nxt;
					req.rd_en   = 1'b1;
					req.rd_addr = nxt;
				end else begin
					leaf_d      = s_q;
					fin.en      = 1'b1;
					fin.leaf    = s_q;
					fin.matched = 1'b1;
					state_d     = S_IDLE;
				end
			end

			default: state_d = S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			started_q <= 1'b0;
			leaf_q    <= '0;
			init_q    <= '0;
			nst_q     <= hsme_pkg::link_t'(hsme_pkg::STATE_COUNT);
		end else begin
			state_q   <= state_d;
			started_q <= started_d;
			leaf_q    <= leaf_d;
			init_q    <= init_d;
			nst_q     <= nst_d;
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		s_q <= s_d; dest_q <= dest_d; last_q <= last_d; lvl_q <= lvl_d;
		k_q <= k_d; n_q <= n_d; dn_q <= dn_d; xn_q <= xn_d; e_q <= e_d;
		ent_q <= ent_d; j_q <= j_d;
		lc_q <= lc_d; lcp_q <= lcp_d; pf_q <= pf_d; dc_q <= dc_d; xc_q <= xc_d;
	end

endmodule

`default_nettype wire

// ----- hdl/hierarchical_state_machine_engine_core.sv -----
// ----------------------------------------------------------------------------
// hierarchical_state_machine_engine_core
// Hierarchical state machine engine with shallow history.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (valid/ready) are table writes, start, or event dispatch.
//   Each request yields its exit/enter/default-entry notifications and then
//   one completion (last_of_run high), all carrying the final active leaf and
//   the matched flag, on the output channel (valid/ready).
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
//   the user is to write it between requests; the block does not enforce this.
//   The entry memory has a registered read, and each walk step waits for one
//   read. An event may add an ancestry walk of the last exited state. Results
//   leave at one per cycle while the receiver is ready, 1 to 17 of them.
//   A new request is accepted once the previous results are handed to the
//   output register; the completion may still wait there.
//   Reset clears the history valid bits, the active leaf and the started flag
//   and sets initial state 0, count 64; tables stay undefined until written.
//   A stalled receiver holds the output register and the drain.
// ----------------------------------------------------------------------------
`default_nettype none

module hierarchical_state_machine_engine_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [5:0]  entry_index,
	input  wire logic signed [6:0] parent_of_entry,
	input  wire logic signed [6:0] default_child_of_entry,
	input  wire logic        entry_keeps_history,
	input  wire logic        event_handled,
	input  wire logic [2:0]  handler_level,
	input  wire logic [5:0]  dest_state,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       action_kind,
	output logic [5:0]       action_state,
	output logic [5:0]       active_leaf,
	output logic             event_matched,
	output logic             last_of_run,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [6:0]  cfg_data
);

	hsme_pkg::tbl_req_t  req;
	hsme_pkg::res_push_t push;
	hsme_pkg::res_fin_t  fin;
	hsme_pkg::ent_t      ent_rd;
	hsme_pkg::state_t    hist_rd;
	logic                hist_vld;
	logic                res_busy;

	assign cfg_ready = 1'b1;

	hsme_ctrl u_ctrl (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.in_valid               (in_valid),
		.in_ready               (in_ready),
		.req_type               (req_type),
		.entry_index            (entry_index),
		.parent_of_entry        (parent_of_entry),
		.default_child_of_entry (default_child_of_entry),
		.entry_keeps_history    (entry_keeps_history),
		.event_handled          (event_handled),
		.handler_level          (handler_level),
		.dest_state             (dest_state),
		.cfg_valid              (cfg_valid),
		.cfg_index              (cfg_index),
		.cfg_data               (cfg_data),
		.res_busy               (res_busy),
		.ent_rd                 (ent_rd),
		.hist_rd                (hist_rd),
		.hist_vld               (hist_vld),
		.req                    (req),
		.push                   (push),
		.fin                    (fin)
	);

	hsme_tables u_tables (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.ent_rd   (ent_rd),
		.hist_rd  (hist_rd),
		.hist_vld (hist_vld)
	);

	hsme_results u_results (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.fin           (fin),
		.busy          (res_busy),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.action_kind   (action_kind),
		.action_state  (action_state),
		.active_leaf   (active_leaf),
		.event_matched (event_matched),
		.last_of_run   (last_of_run)
	);

endmodule

`default_nettype wire
